### hw/rtl/sse_pkg.sv
package sse_pkg;

  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 17;
  localparam int SUM_W    = 48;
  localparam int SQ_W     = 64;
  localparam int SUMSQ_W  = 79;
  localparam int MEAN_W   = 40;
  localparam int VAR_W    = 63;
  localparam int STD_W    = 39;
  localparam int ALU_W    = 96;
  localparam int NUM_W    = 112;
  localparam int REM_W    = 58;
  localparam int ROOT_W   = 56;
  localparam int STEP_W   = 7;

  localparam logic [STEP_W-1:0] STEPS_NS   = STEP_W'(COUNT_W);
  localparam logic [STEP_W-1:0] STEPS_SS   = STEP_W'(SUM_W);
  localparam logic [STEP_W-1:0] STEPS_MEAN = STEP_W'(SUM_W + 8);
  localparam logic [STEP_W-1:0] STEPS_DEV  = STEP_W'(ALU_W);
  localparam logic [STEP_W-1:0] STEPS_ROOT = STEP_W'(ROOT_W);

  localparam logic signed [SAMPLE_W-1:0] INT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] INT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_NS,
    S_SS,
    S_DIVM,
    S_MNEG,
    S_DIVV1,
    S_DIVV2,
    S_SQRT,
    S_DIVS
  } state_t;

endpackage

### hw/rtl/series_statistics_engine.sv
// Series statistics over signed 32-bit samples. A sample transfers on a clock edge with start
// high and busy low; in_last_sample closes the series. After an ordinary sample busy is high
// while the squared sample is added into the sum of squares, and the next sample is taken
// only once busy is low again. After the last sample busy stays high while one shared 96-bit
// add/subtract unit runs, in turn, a 17-step shift-add for count * sum of squares, a 48-step
// shift-subtract of the squared sum, a 56-step divide for the mean, a negate, two 96-step
// divides by the count for the variance, a 56-step square root and a 56-step divide for the
// standard deviation. The result is on the out_ ports for exactly one cycle with out_valid
// high, the first cycle that busy is low again; there is no way to hold it off, so it must
// be captured then. Samples past MAX_COUNT are dropped and flagged in out_count_overflow.
module series_statistics_engine
  import sse_pkg::*;
#(
  parameter int MAX_COUNT = 65536
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic                        in_last_sample,
  output logic                        out_valid,
  output logic [COUNT_W-1:0]          out_sample_count,
  output logic signed [SUM_W-1:0]     out_total,
  output logic signed [SAMPLE_W-1:0]  out_smallest,
  output logic signed [SAMPLE_W-1:0]  out_largest,
  output logic signed [MEAN_W-1:0]    out_mean_q8,
  output logic [VAR_W-1:0]            out_variance_int,
  output logic [STD_W-1:0]            out_std_dev_q8,
  output logic                        out_count_overflow
);

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]         count_r, count_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SUMSQ_W-1:0]         sumsq_r, sumsq_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       last_r, last_nxt;
  logic [SQ_W-1:0]            sq_r, sq_nxt;

  logic [ALU_W-1:0]           acc_r, acc_nxt;
  logic [ALU_W-1:0]           mcand_r, mcand_nxt;
  logic [SUM_W-1:0]           mplier_r, mplier_nxt;
  logic [STEP_W-1:0]          cnt_r, cnt_nxt;
  logic [NUM_W-1:0]           num_r, num_nxt;
  logic [REM_W-1:0]           rem_r, rem_nxt;
  logic [ALU_W-1:0]           quo_r, quo_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]         out_count_r, out_count_nxt;
  logic signed [SUM_W-1:0]    out_total_r, out_total_nxt;
  logic signed [SAMPLE_W-1:0] out_min_r, out_min_nxt;
  logic signed [SAMPLE_W-1:0] out_max_r, out_max_nxt;
  logic signed [MEAN_W-1:0]   out_mean_r, out_mean_nxt;
  logic [VAR_W-1:0]           out_var_r, out_var_nxt;
  logic [STD_W-1:0]           out_std_r, out_std_nxt;
  logic                       out_ovf_r, out_ovf_nxt;

  // shared add/subtract unit
  logic [ALU_W-1:0] alu_a, alu_b, alu_y;
  logic             alu_sub, alu_ge;
  logic [ALU_W:0]   alu_sum;

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {ALU_W{alu_sub}}}
                 + {{ALU_W{1'b0}}, alu_sub};
  assign alu_y   = alu_sum[ALU_W-1:0];
  assign alu_ge  = alu_sum[ALU_W];

  logic [SAMPLE_W-1:0] smag;
  logic [SQ_W-1:0]     sq_prod;
  logic [SUM_W-1:0]    sum_mag;
  logic                take;
  logic [COUNT_W:0]    div_r2;
  logic [REM_W+1:0]    sqrt_r2;
  logic [REM_W-1:0]    div_rem, sqrt_rem;
  logic [ALU_W-1:0]    quo_step;
  logic                last_step;

  assign smag      = in_sample[SAMPLE_W-1] ? (~in_sample + SAMPLE_W'(1)) : in_sample;
  assign sq_prod   = SQ_W'(smag) * SQ_W'(smag);
  assign sum_mag   = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;
  assign take      = (count_r != COUNT_W'(MAX_COUNT));
  assign div_r2    = {rem_r[COUNT_W-1:0], num_r[NUM_W-1]};
  assign sqrt_r2   = {rem_r, num_r[NUM_W-1 -: 2]};
  assign div_rem   = REM_W'(alu_ge ? alu_y[COUNT_W-1:0] : div_r2[COUNT_W-1:0]);
  assign sqrt_rem  = alu_ge ? alu_y[REM_W-1:0] : sqrt_r2[REM_W-1:0];
  assign quo_step  = {quo_r[ALU_W-2:0], alu_ge};
  assign last_step = (cnt_r == STEP_W'(1));

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r) inside
      S_ACC: begin
        alu_a = ALU_W'(sumsq_r);
        alu_b = ALU_W'(sq_r);
      end
      S_NS: begin
        alu_a = acc_r;
        alu_b = mplier_r[0] ? mcand_r : '0;
      end
      S_SS: begin
        alu_a   = acc_r;
        alu_b   = mplier_r[0] ? mcand_r : '0;
        alu_sub = 1'b1;
      end
      S_DIVM, S_DIVV1, S_DIVV2, S_DIVS: begin
        alu_a   = ALU_W'(div_r2);
        alu_b   = ALU_W'(count_r);
        alu_sub = 1'b1;
      end
      S_SQRT: begin
        alu_a   = ALU_W'(sqrt_r2);
        alu_b   = ALU_W'({quo_r[ROOT_W-1:0], 2'b01});
        alu_sub = 1'b1;
      end
      S_MNEG: begin
        alu_b   = ALU_W'(quo_r[MEAN_W-1:0]);
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    sq_nxt        = sq_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    cnt_nxt       = cnt_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    out_total_nxt = out_total_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_mean_nxt  = out_mean_r;
    out_var_nxt   = out_var_r;
    out_std_nxt   = out_std_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r) inside
      S_IDLE: begin
        if (start) begin
          last_nxt  = in_last_sample;
          state_nxt = S_ACC;
          if (take) begin
            count_nxt = count_r + COUNT_W'(1);
            sum_nxt   = sum_r + SUM_W'(in_sample);
            sq_nxt    = sq_prod;
            if (in_sample < min_r) min_nxt = in_sample;
            if (in_sample > max_r) max_nxt = in_sample;
          end else begin
            sq_nxt  = '0;
            ovf_nxt = 1'b1;
          end
        end
      end
      S_ACC: begin
        sumsq_nxt = alu_y[SUMSQ_W-1:0];
        if (last_r) begin
          acc_nxt    = '0;
          mcand_nxt  = ALU_W'(alu_y[SUMSQ_W-1:0]);
          mplier_nxt = SUM_W'(count_r);
          cnt_nxt    = STEPS_NS;
          state_nxt  = S_NS;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_NS: begin
        acc_nxt    = alu_y;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - STEP_W'(1);
        if (last_step) begin
          mcand_nxt  = ALU_W'(sum_mag);
          mplier_nxt = sum_mag;
          cnt_nxt    = STEPS_SS;
          state_nxt  = S_SS;
        end
      end
      S_SS: begin
        acc_nxt    = alu_y;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - STEP_W'(1);
        if (last_step) begin
          num_nxt   = {sum_mag, 8'd0, {(NUM_W-SUM_W-8){1'b0}}};
          rem_nxt   = '0;
          quo_nxt   = '0;
          cnt_nxt   = STEPS_MEAN;
          state_nxt = S_DIVM;
        end
      end
      S_DIVM, S_DIVV1, S_DIVV2, S_DIVS: begin
        num_nxt = num_r << 1;
        rem_nxt = div_rem;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - STEP_W'(1);
        if (last_step) begin
          rem_nxt = '0;
          unique case (state_r) inside
            S_DIVM: begin
              state_nxt = S_MNEG;
            end
            S_DIVV1: begin
              num_nxt   = {quo_step, {(NUM_W-ALU_W){1'b0}}};
              cnt_nxt   = STEPS_DEV;
              state_nxt = S_DIVV2;
            end
            S_DIVV2: begin
              out_var_nxt = quo_step[VAR_W-1:0];
              num_nxt     = {acc_r, {(NUM_W-ALU_W){1'b0}}};
              quo_nxt     = '0;
              cnt_nxt     = STEPS_ROOT;
              state_nxt   = S_SQRT;
            end
            default: begin
              out_std_nxt   = quo_step[STD_W-1:0];
              out_count_nxt = count_r;
              out_total_nxt = sum_r;
              out_min_nxt   = min_r;
              out_max_nxt   = max_r;
              out_ovf_nxt   = ovf_r;
              out_valid_nxt = 1'b1;
              count_nxt     = '0;
              sum_nxt       = '0;
              sumsq_nxt     = '0;
              min_nxt       = INT_MAX;
              max_nxt       = INT_MIN;
              ovf_nxt       = 1'b0;
              state_nxt     = S_IDLE;
            end
          endcase
        end
      end
      S_MNEG: begin
        out_mean_nxt = sum_r[SUM_W-1] ? alu_y[MEAN_W-1:0] : quo_r[MEAN_W-1:0];
        num_nxt      = {acc_r, {(NUM_W-ALU_W){1'b0}}};
        rem_nxt      = '0;
        quo_nxt      = '0;
        cnt_nxt      = STEPS_DEV;
        state_nxt    = S_DIVV1;
      end
      S_SQRT: begin
        num_nxt = num_r << 2;
        rem_nxt = sqrt_rem;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - STEP_W'(1);
        if (last_step) begin
          num_nxt   = {quo_step[ROOT_W-1:0], {(NUM_W-ROOT_W){1'b0}}};
          rem_nxt   = '0;
          quo_nxt   = '0;
          cnt_nxt   = STEPS_ROOT;
          state_nxt = S_DIVS;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      min_r       <= INT_MAX;
      max_r       <= INT_MIN;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      sumsq_r     <= sumsq_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    sq_r        <= sq_nxt;
    acc_r       <= acc_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    cnt_r       <= cnt_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    out_count_r <= out_count_nxt;
    out_total_r <= out_total_nxt;
    out_min_r   <= out_min_nxt;
    out_max_r   <= out_max_nxt;
    out_mean_r  <= out_mean_nxt;
    out_var_r   <= out_var_nxt;
    out_std_r   <= out_std_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_sample_count   = out_count_r;
  assign out_total          = out_total_r;
  assign out_smallest       = out_min_r;
  assign out_largest        = out_max_r;
  assign out_mean_q8        = out_mean_r;
  assign out_variance_int   = out_var_r;
  assign out_std_dev_q8     = out_std_r;
  assign out_count_overflow = out_ovf_r;

endmodule
